// ===== sv/three_phase_sine_pwm_core_macros.svh =====
// Assertion macros shared by the sine PWM core RTL.
// Each macro expects aclk and aresetn in scope; no other dependencies.
`ifndef THREE_PHASE_SINE_PWM_CORE_MACROS_SVH
`define THREE_PHASE_SINE_PWM_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define TPSP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define TPSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/tpsp_pkg.sv =====
// Package for the three-phase sine PWM core: widths, constants, types and
// the elaboration-time quarter-wave sine table. No dependencies.
`timescale 1ns / 1ps

package tpsp_pkg;

    // Phase accumulator and table addressing
    localparam int PHASE_BITS     = 32;
    localparam int STEP_BITS      = 32;
    localparam int SINE_ADDR_BITS = 10;
    localparam int QTR_BITS       = SINE_ADDR_BITS - 2;
    localparam int QTR_SIZE       = 1 << QTR_BITS;

    localparam logic [STEP_BITS-1:0]  PHASE_STEP_RESET = 32'd42949673;
    localparam logic [PHASE_BITS-1:0] PHASE_ALL_ONES   = {PHASE_BITS{1'b1}};
    localparam logic [PHASE_BITS-1:0] PHASE_THIRD      = PHASE_ALL_ONES / 3;

    // Sine magnitude, Q1.15 without sign
    localparam int                   SINE_MAG_BITS = 15;
    localparam logic [SINE_MAG_BITS-1:0] SINE_FULL = 15'd32767;

    // Duty scaling: duty = (500*s + 500*2^15) >> 16
    localparam int                   DUTY_BITS   = 9;
    localparam int                   PROD_BITS   = 24;
    localparam int                   LEVEL_BITS  = 25;
    localparam int                   DUTY_SHIFT  = 16;
    localparam logic [DUTY_BITS-1:0] DUTY_AMPL   = 9'd500;
    localparam logic [DUTY_BITS-1:0] DUTY_MAX    = 9'd499;
    localparam logic [LEVEL_BITS-1:0] DUTY_OFFSET = 25'd16384000;

    // Taylor series constants (Q30 fixed point)
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] TaylorDiv1  = 64'd6;
    localparam logic [63:0] TaylorDiv2  = 64'd20;
    localparam logic [63:0] TaylorDiv3  = 64'd42;
    localparam logic [63:0] TaylorDiv4  = 64'd72;
    localparam logic [63:0] TaylorDiv5  = 64'd110;
    localparam logic [63:0] Q15_ROUND   = 64'd16384;
    localparam logic [63:0] Q15_SAT     = 64'd32767;

    typedef logic [SINE_ADDR_BITS-1:0] sine_addr_t;
    typedef logic [QTR_SIZE-1:0][SINE_MAG_BITS-1:0] qtr_table_t;

    // Table addresses of the three phases for one tick
    typedef struct packed {
        sine_addr_t addr_a;
        sine_addr_t addr_b;
        sine_addr_t addr_c;
    } phase_addr_t;

    // Controls from the handshake logic to the phase unit
    typedef struct packed {
        logic tick_adv;
        logic step_wr;
    } phase_ctl_t;

    // Widen or truncate the configured step to the accumulator width
    function automatic logic [PHASE_BITS-1:0] step_to_phase(input logic [STEP_BITS-1:0] step);
        logic [63:0] wide;
        wide = {32'd0, step};
        return wide[PHASE_BITS-1:0];
    endfunction

    // Quarter-wave sine, evaluated once at elaboration
    function automatic qtr_table_t build_qtr_table();
        qtr_table_t  tbl;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] q15;
        for (int k = 0; k < QTR_SIZE; k++) begin
            x    = (64'(k) * HALF_PI_Q30) >> QTR_BITS;
            x2   = (x * x) >> 30;
            term = x;
            sum  = x;
            term = ((term * x2) >> 30) / TaylorDiv1;
            sum  = sum - term;
            term = ((term * x2) >> 30) / TaylorDiv2;
            sum  = sum + term;
            term = ((term * x2) >> 30) / TaylorDiv3;
            sum  = sum - term;
            term = ((term * x2) >> 30) / TaylorDiv4;
            sum  = sum + term;
            term = ((term * x2) >> 30) / TaylorDiv5;
            sum  = sum - term;
            q15  = (sum + Q15_ROUND) >> 15;
            if (q15 > Q15_SAT) begin
                q15 = Q15_SAT;
            end
            tbl[k] = q15[SINE_MAG_BITS-1:0];
        end
        return tbl;
    endfunction

    localparam qtr_table_t QTR_TABLE = build_qtr_table();

endpackage

// ===== sv/three_phase_sine_pwm_core.sv =====
// An accepted tick beat passes both pipeline stages to its result beat on m_.
// Throughput: one tick per cycle; the address register and the result register
// form a two-stage pipeline, each stage moving when the stage after it is free.
// Config writes are always taken (cfg_ready high) and apply to the next tick.
// Reset (aresetn low, synchronous) sets step to its default, zeroes the phase
// and the held duties, and empties both stages; no clearing pass is needed.
`timescale 1ns / 1ps
`include "three_phase_sine_pwm_core_macros.svh"

module three_phase_sine_pwm_core
    import tpsp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [STEP_BITS-1:0] cfg_phase_step,
    // tick input
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_run_enable,
    // compare values
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [DUTY_BITS-1:0] m_duty_a,
    output logic [DUTY_BITS-1:0] m_duty_b,
    output logic [DUTY_BITS-1:0] m_duty_c,
    output logic                 m_updated
);

    phase_ctl_t           ctl;
    phase_addr_t          addr;
    logic                 s1_valid_reg;
    logic                 s1_run_reg;
    logic                 m_valid_reg;
    logic                 m_updated_reg;
    logic [DUTY_BITS-1:0] duty_a_reg;
    logic [DUTY_BITS-1:0] duty_b_reg;
    logic [DUTY_BITS-1:0] duty_c_reg;
    logic [DUTY_BITS-1:0] duty_a_next;
    logic [DUTY_BITS-1:0] duty_b_next;
    logic [DUTY_BITS-1:0] duty_c_next;
    logic                 out_free;
    logic                 out_load;
    logic                 tick_accept;

    // Pipeline flow control
    assign out_free    = !m_valid_reg || m_ready;
    assign out_load    = out_free && s1_valid_reg;
    assign s_ready     = !s1_valid_reg || out_free;
    assign tick_accept = s_valid && s_ready;
    assign cfg_ready   = 1'b1;

    assign ctl.tick_adv = tick_accept;
    assign ctl.step_wr  = cfg_valid && cfg_ready;

    tpsp_phase u_phase (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .step_data (cfg_phase_step),
        .addr      (addr)
    );

    tpsp_duty u_duty_a (.addr(addr.addr_a), .duty(duty_a_next));
    tpsp_duty u_duty_b (.addr(addr.addr_b), .duty(duty_b_next));
    tpsp_duty u_duty_c (.addr(addr.addr_c), .duty(duty_c_next));

    // Stage 1: run flag next to the registered addresses
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (tick_accept) begin
            s1_run_reg <= s_run_enable;
        end
    end

    // Stage 2: result beat; duty registers are the held compare values
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            duty_a_reg  <= '0;
            duty_b_reg  <= '0;
            duty_c_reg  <= '0;
        end else begin
            if (out_free) begin
                m_valid_reg <= s1_valid_reg;
            end
            if (out_load && s1_run_reg) begin
                duty_a_reg <= duty_a_next;
                duty_b_reg <= duty_b_next;
                duty_c_reg <= duty_c_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_updated_reg <= s1_run_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_duty_a  = duty_a_reg;
    assign m_duty_b  = duty_b_reg;
    assign m_duty_c  = duty_c_reg;
    assign m_updated = m_updated_reg;

    `TPSP_ASSERT_NOW(a_duty_range, 1'b1,
        (duty_a_reg <= DUTY_MAX) && (duty_b_reg <= DUTY_MAX) && (duty_c_reg <= DUTY_MAX),
        "held duty above maximum")
    `TPSP_ASSERT_NEXT(a_hold_when_idle, out_load && !s1_run_reg,
        $stable(duty_a_reg) && $stable(duty_b_reg) && $stable(duty_c_reg),
        "duties changed on a tick without run")
    `TPSP_ASSERT_NOW(a_full_stall, s1_valid_reg && m_valid_reg && !m_ready, !s_ready,
        "tick taken while both stages are full")

endmodule

// ===== sv/tpsp_phase.sv =====
// Phase unit: step register, wrapping phase accumulator and the registered
// table addresses of phases A, B and C. Depends on tpsp_pkg.
`timescale 1ns / 1ps
`include "three_phase_sine_pwm_core_macros.svh"

module tpsp_phase
    import tpsp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  phase_ctl_t           ctl,
    input  logic [STEP_BITS-1:0] step_data,
    output phase_addr_t          addr
);

    logic [STEP_BITS-1:0]  phase_step_reg;
    logic [PHASE_BITS-1:0] phase_acc_reg;
    logic [PHASE_BITS-1:0] phase_acc_next;
    logic [PHASE_BITS-1:0] phase_b;
    logic [PHASE_BITS-1:0] phase_c;
    phase_addr_t           addr_reg;
    phase_addr_t           addr_next;

    // Offsets of +1/3 and -1/3 turn, wrapping
    always_comb begin
        phase_b        = phase_acc_reg + PHASE_THIRD;
        phase_c        = phase_acc_reg - PHASE_THIRD;
        phase_acc_next = phase_acc_reg + step_to_phase(phase_step_reg);
        addr_next.addr_a = phase_acc_reg[PHASE_BITS-1 -: SINE_ADDR_BITS];
        addr_next.addr_b = phase_b[PHASE_BITS-1 -: SINE_ADDR_BITS];
        addr_next.addr_c = phase_c[PHASE_BITS-1 -: SINE_ADDR_BITS];
    end

    // Step register and accumulator
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_step_reg <= PHASE_STEP_RESET;
            phase_acc_reg  <= '0;
        end else begin
            if (ctl.step_wr) begin
                phase_step_reg <= step_data;
            end
            if (ctl.tick_adv) begin
                phase_acc_reg <= phase_acc_next;
            end
        end
    end

    // Addresses for the tick just taken
    always_ff @(posedge aclk) begin
        if (ctl.tick_adv) begin
            addr_reg <= addr_next;
        end
    end

    assign addr = addr_reg;

    `TPSP_ASSERT_NEXT(a_acc_holds, !ctl.tick_adv, $stable(phase_acc_reg), "phase moved without a tick")
    `TPSP_ASSERT_NEXT(a_step_holds, !ctl.step_wr, $stable(phase_step_reg), "step changed without a write")
    `TPSP_ASSERT_NEXT(a_acc_adds, ctl.tick_adv && !ctl.step_wr,
        phase_acc_reg == $past(phase_acc_next), "phase did not advance by the step")

endmodule

// ===== sv/tpsp_duty.sv =====
// Duty unit: quarter-wave sine lookup with quadrant folding, then scaling
// of the Q1.15 sample to a 0..499 compare value. Depends on tpsp_pkg.
`timescale 1ns / 1ps

module tpsp_duty
    import tpsp_pkg::*;
(
    input  sine_addr_t           addr,
    output logic [DUTY_BITS-1:0] duty
);

    logic [1:0]               quad;
    logic [QTR_BITS-1:0]      j;
    logic [QTR_BITS-1:0]      idx;
    logic [SINE_MAG_BITS-1:0] mag;
    logic [PROD_BITS-1:0]     prod;
    logic [LEVEL_BITS-1:0]    level;

    always_comb begin
        quad = addr[SINE_ADDR_BITS-1 -: 2];
        j    = addr[QTR_BITS-1:0];
        // Odd quadrants run the table backwards; the peak is not in the table
        idx  = quad[0] ? (QTR_BITS'(0) - j) : j;
        if (quad[0] && (j == '0)) begin
            mag = SINE_FULL;
        end else begin
            mag = QTR_TABLE[idx];
        end
        // Lower half-wave subtracts from the mid level
        prod  = PROD_BITS'(mag) * PROD_BITS'(DUTY_AMPL);
        level = quad[1] ? (DUTY_OFFSET - LEVEL_BITS'(prod))
                        : (DUTY_OFFSET + LEVEL_BITS'(prod));
        duty  = level[DUTY_SHIFT +: DUTY_BITS];
    end

endmodule

// ===== sim/tb_top.sv =====
// Testbench for three_phase_sine_pwm_core: random tick beats with idling on both sides,
// checked against a local phase-accumulator and quarter-wave sine predictor.
// Depends on tpsp_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_top;
    import tpsp_pkg::*;

    // Predictor constants
    localparam logic [63:0]           PI_HALF_Q30 = 64'd1686629713;
    localparam int                    DUTY_SPAN   = 500;
    localparam logic [PHASE_BITS-1:0] TURN_THIRD  = {PHASE_BITS{1'b1}} / 3;

    // One result beat
    typedef struct packed {
        logic [DUTY_BITS-1:0] a;
        logic [DUTY_BITS-1:0] b;
        logic [DUTY_BITS-1:0] c;
        logic                 upd;
    } duty_beat_t;

    logic                 aclk           = 1'b0;
    logic                 aresetn        = 1'b0;
    logic                 cfg_valid      = 1'b0;
    logic                 cfg_ready;
    logic [STEP_BITS-1:0] cfg_phase_step = '0;
    logic                 s_valid        = 1'b0;
    logic                 s_ready;
    logic                 s_run_enable   = 1'b0;
    logic                 m_valid;
    logic                 m_ready        = 1'b0;
    logic [DUTY_BITS-1:0] m_duty_a;
    logic [DUTY_BITS-1:0] m_duty_b;
    logic [DUTY_BITS-1:0] m_duty_c;
    logic                 m_updated;

    // Stimulus and scoreboard state
    bit         pending_ticks[$];
    duty_beat_t duty_expect_q[$];
    int         ticks_open = 0;
    int         fail_count = 0;
    bit         quiet_mode = 1'b0;
    int         src_gap    = 0;
    int         sink_hold  = 0;

    // Predictor state
    int                    sine_qtr[QTR_SIZE];
    logic [STEP_BITS-1:0]  model_step;
    logic [PHASE_BITS-1:0] model_phase;
    logic [DUTY_BITS-1:0]  model_held[3];

    three_phase_sine_pwm_core i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_phase_step (cfg_phase_step),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_run_enable   (s_run_enable),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_duty_a       (m_duty_a),
        .m_duty_b       (m_duty_b),
        .m_duty_c       (m_duty_c),
        .m_updated      (m_updated)
    );

    always #5 aclk = ~aclk;

    // Quarter-wave sine in Q1.15 from a truncated Taylor series in Q30
    function automatic void build_sine_quarter();
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] q15;
        for (int k = 0; k < QTR_SIZE; k++) begin
            x    = (64'(k) * PI_HALF_Q30) >> QTR_BITS;
            x2   = (x * x) >> 30;
            term = x;
            sum  = x;
            for (int n = 1; n <= 5; n++) begin
                term = ((term * x2) >> 30) / (64'(2 * n) * 64'(2 * n + 1));
                if (n % 2 == 1) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            q15 = (sum + 64'd16384) >> 15;
            if (q15 > 64'd32767) begin
                q15 = 64'd32767;
            end
            sine_qtr[k] = int'(q15);
        end
    endfunction

    // Signed Q1.15 sine sample at a phase, folded from the quarter table
    function automatic int sine_sample(input logic [PHASE_BITS-1:0] ph);
        logic [SINE_ADDR_BITS-1:0] addr;
        logic [1:0]                quad;
        int                        j;
        int                        mag;
        addr = ph[PHASE_BITS-1 -: SINE_ADDR_BITS];
        quad = addr[SINE_ADDR_BITS-1 -: 2];
        j    = int'(addr[QTR_BITS-1:0]);
        if (quad[0]) begin
            // falling quarter; its first entry is the crest
            mag = (j == 0) ? 32767 : sine_qtr[QTR_SIZE - j];
        end else begin
            mag = sine_qtr[j];
        end
        return quad[1] ? -mag : mag;
    endfunction

    // floor(500*s + 500) in Q15, then halved
    function automatic logic [DUTY_BITS-1:0] duty_from_sample(input int s);
        logic [31:0] lvl;
        lvl = DUTY_SPAN * s + DUTY_SPAN * 32768;
        return DUTY_BITS'(lvl >> 16);
    endfunction

    // One tick: duties from the current phase, then the accumulator steps
    function automatic duty_beat_t advance_duties(input logic run);
        duty_beat_t            beat;
        logic [PHASE_BITS-1:0] pa;
        logic [DUTY_BITS-1:0]  da;
        logic [DUTY_BITS-1:0]  db;
        logic [DUTY_BITS-1:0]  dc;
        pa          = model_phase;
        da          = duty_from_sample(sine_sample(pa));
        db          = duty_from_sample(sine_sample(pa + TURN_THIRD));
        dc          = duty_from_sample(sine_sample(pa - TURN_THIRD));
        model_phase = pa + PHASE_BITS'(model_step);
        if (run) begin
            model_held[0] = da;
            model_held[1] = db;
            model_held[2] = dc;
        end
        beat.a   = model_held[0];
        beat.b   = model_held[1];
        beat.c   = model_held[2];
        beat.upd = run;
        return beat;
    endfunction

    function automatic void check_field(input string fname, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
            fail_count++;
        end
    endfunction

    // Mostly short gaps, a few long ones; none in quiet phases
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_mode || r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic void queue_tick(input bit run);
        pending_ticks.push_back(run);
        ticks_open++;
    endfunction

    task automatic queue_random(input int n, input int run_pct);
        for (int i = 0; i < n; i++) begin
            queue_tick($urandom_range(0, 99) < run_pct);
        end
    endtask

    // Block until every queued tick has produced its result beat
    task automatic wait_drained();
        while (ticks_open != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_phase_step(input logic [STEP_BITS-1:0] v);
        cfg_valid      <= 1'b1;
        cfg_phase_step <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Tick driver: holds a beat until taken, random gaps between beats
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap = 0;
        end else if (!s_valid || s_ready) begin
            if (src_gap > 0) begin
                s_valid <= 1'b0;
                src_gap--;
            end else if (pending_ticks.size() != 0) begin
                s_valid      <= 1'b1;
                s_run_enable <= pending_ticks.pop_front();
                src_gap = pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result sink: random back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            sink_hold = 0;
        end else if (sink_hold > 0) begin
            m_ready <= 1'b0;
            sink_hold--;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) begin
                sink_hold = pick_gap();
            end
        end
    end

    // Monitor: tracks config and tick beats, checks result beats in order
    always @(posedge aclk) begin
        duty_beat_t want;
        if (!aresetn) begin
            model_step    = PHASE_STEP_RESET;
            model_phase   = '0;
            model_held[0] = '0;
            model_held[1] = '0;
            model_held[2] = '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                model_step = cfg_phase_step;
            end
            if (m_valid && m_ready) begin
                if (duty_expect_q.size() == 0) begin
                    $display("%0t ns: result beat with none expected, duties %0d %0d %0d",
                             $time, m_duty_a, m_duty_b, m_duty_c);
                    fail_count++;
                end else begin
                    want = duty_expect_q.pop_front();
                    check_field("duty_a", want.a, m_duty_a);
                    check_field("duty_b", want.b, m_duty_b);
                    check_field("duty_c", want.c, m_duty_c);
                    check_field("updated", want.upd, m_updated);
                    ticks_open--;
                end
            end
            if (s_valid && s_ready) begin
                duty_expect_q.push_back(advance_duties(s_run_enable));
            end
        end
    end

    // Main sequence
    initial begin
        logic [STEP_BITS-1:0] step;
        int                   run_pct;
        build_sine_quarter();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // default step: held values start at zero while run is off
        queue_tick(1'b0);
        queue_tick(1'b0);
        queue_tick(1'b1);
        queue_tick(1'b1);
        queue_tick(1'b1);
        queue_tick(1'b0);
        queue_tick(1'b1);
        wait_drained();

        // zero step: phase frozen
        write_phase_step('0);
        queue_random(3, 100);
        wait_drained();

        // all-ones step: phase runs backward by one
        write_phase_step('1);
        queue_random(3, 100);
        wait_drained();

        // quarter-turn step: each tick moves every phase on by one quadrant
        write_phase_step(32'h4000_0000);
        queue_random(5, 100);
        wait_drained();

        // one table address per tick, run toggling
        write_phase_step(32'h0040_0000);
        for (int i = 0; i < 6; i++) begin
            queue_tick(i % 2 == 1);
        end
        wait_drained();

        // random phases
        for (int p = 0; p < 14; p++) begin
            case ($urandom_range(0, 9))
                0: step = '0;
                1: step = '1;
                2: step = PHASE_STEP_RESET;
                3, 4, 5: step = $urandom();
                default: step = $urandom_range(1, 32'h0400_0000);
            endcase
            case ($urandom_range(0, 3))
                0: run_pct = 100;
                1: run_pct = 85;
                2: run_pct = 50;
                default: run_pct = 10;
            endcase
            write_phase_step(step);
            quiet_mode = ($urandom_range(0, 3) == 0);
            queue_random($urandom_range(100, 140), run_pct);
            wait_drained();
        end
        quiet_mode = 1'b0;

        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("** three_phase_sine_pwm_core: PASSED **");
        end else begin
            $display("** three_phase_sine_pwm_core: FAILED **");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #6_000_000;
        $display("** three_phase_sine_pwm_core: FAILED **");
        $finish;
    end

endmodule
